// ===== src/set_assoc_cache_tag_lookup_defines.svh =====
// Assertion macros for the set-associative cache tag lookup checker.
// Depends on nothing; the using module must have clk_i and rst_ni in scope.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SACTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SACTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sactl_pkg.sv =====
// Shared types and codes of the set-associative cache tag lookup.
// Used by the way selector, the top level and the testbench.
package sactl_pkg;

  // Fixed field widths of the request and result.
  localparam int SetInW   = 8;
  localparam int TagInW   = 20;
  localparam int WayOutW  = 3;
  localparam int StatW    = 32;
  localparam int StampW   = 32;
  localparam int WayMaxW  = 6;
  localparam int CfgDataW = 4;

  // Access kind.
  localparam logic ActRead  = 1'b0;
  localparam logic ActWrite = 1'b1;

  // Replacement policy codes.
  localparam logic PolicyLru  = 1'b0;
  localparam logic PolicyFifo = 1'b1;

  // Configuration register indexes.
  localparam logic CfgPolicy = 1'b0;
  localparam logic CfgWays   = 1'b1;

  // Outcome of the way search over one set.
  typedef struct packed {
    logic               hit;
    logic               wb;
    logic [WayMaxW-1:0] way;
  } sel_t;

endpackage

// ===== src/set_assoc_cache_tag_lookup.sv =====
// Top level of the set-associative write-back cache tag and status store.
// Depends on sactl_pkg and sactl_way_select.
//
// A request reads its set row from memory; then all ways are compared, the
// hit or victim way is picked and the updated row is written back once the
// output register can take the result. The single memory port and this
// read-modify-write loop set the rate. A result waits in an output register,
// and the next request is taken while it waits. After reset a clearing pass
// zeroes the set memory, taking configuration writes but no request.
module set_assoc_cache_tag_lookup
  import sactl_pkg::*;
#(
  parameter int WAYS     = 8,
  parameter int SETS     = 256,
  parameter int TAG_BITS = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [3:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action [0], set_index [8:1], tag [28:9], zero [31:29]
  input  logic [31:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit [0], wrote_back [1], way_used [4:2], read_hit_count [36:5],
  // read_miss_count [68:37], write_hit_count [100:69],
  // write_miss_count [132:101], writeback_count [164:133], zero [167:165]
  output logic [167:0] m_axis_tdata
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W = $clog2(WAYS + 1);
  localparam int ROW_W = WAYS * (2 + TAG_BITS + StampW);
  localparam int N_RST = (8 > WAYS) ? WAYS : 8;
  localparam int V_LO  = 0;
  localparam int D_LO  = WAYS;
  localparam int T_LO  = 2 * WAYS;
  localparam int S_LO  = 2 * WAYS + WAYS * TAG_BITS;

  typedef logic [SET_W-1:0] set_lut_t [256];

  function automatic set_lut_t build_set_lut();
    set_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = SET_W'(i % SETS);
    end
    return lut;
  endfunction

  localparam set_lut_t SetLut = build_set_lut();

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e              state_q;
  logic [SET_W-1:0]    clr_idx_q;
  logic                policy_q;
  logic [CNT_W-1:0]    n_ways_q;
  logic [CNT_W-1:0]    n_ways_d;
  logic [ROW_W-1:0]    mem [SETS];
  logic [ROW_W-1:0]    rdata_q;
  logic [SET_W-1:0]    set_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                act_q;
  logic [StampW-1:0]   acc_q;
  logic [StatW-1:0]    rd_hit_q, rd_miss_q, wr_hit_q, wr_miss_q, wb_cnt_q;
  logic                out_vld_q;
  logic [167:0]        out_data_q;

  logic                in_acc;
  logic                commit;
  logic [SET_W-1:0]    set_in;
  logic [TAG_BITS-1:0] tag_in;
  sel_t                sel;
  logic [WAY_W-1:0]    way;
  logic [StampW-1:0]   acc_d;
  logic [ROW_W-1:0]    row_d;
  logic [StatW-1:0]    rd_hit_d, rd_miss_d, wr_hit_d, wr_miss_d, wb_cnt_d;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == ST_LOOKUP) && (!out_vld_q || m_axis_tready);
  assign set_in        = SetLut[s_axis_tdata[8:1]];
  assign tag_in        = TAG_BITS'(s_axis_tdata[28:9]);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // Ways count as written, clamped to 1..WAYS.
  always_comb begin
    if (cfg_data_i == '0) begin
      n_ways_d = CNT_W'(1);
    end else if (32'(cfg_data_i) > 32'(WAYS)) begin
      n_ways_d = CNT_W'(WAYS);
    end else begin
      n_ways_d = CNT_W'(cfg_data_i);
    end
  end

  sactl_way_select #(
    .WAYS     (WAYS),
    .TAG_BITS (TAG_BITS),
    .CNT_W    (CNT_W)
  ) u_way_select (
    .valid_i  (rdata_q[V_LO +: WAYS]),
    .dirty_i  (rdata_q[D_LO +: WAYS]),
    .tags_i   (rdata_q[T_LO +: WAYS*TAG_BITS]),
    .stamps_i (rdata_q[S_LO +: WAYS*StampW]),
    .tag_i    (tag_q),
    .n_ways_i (n_ways_q),
    .sel_o    (sel)
  );

  assign way = WAY_W'(sel.way);

  // Updated row and statistics for the request in the lookup cycle.
  always_comb begin
    acc_d     = acc_q + StampW'(1);
    row_d     = rdata_q;
    rd_hit_d  = rd_hit_q;
    rd_miss_d = rd_miss_q;
    wr_hit_d  = wr_hit_q;
    wr_miss_d = wr_miss_q;
    wb_cnt_d  = wb_cnt_q;
    if (sel.hit) begin
      if (policy_q == PolicyLru) begin
        row_d[S_LO + 32'(way)*StampW +: StampW] = acc_d;
      end
      if (act_q == ActWrite) begin
        row_d[D_LO + 32'(way)] = 1'b1;
        wr_hit_d = wr_hit_q + StatW'(1);
      end else begin
        rd_hit_d = rd_hit_q + StatW'(1);
      end
    end else begin
      row_d[T_LO + 32'(way)*TAG_BITS +: TAG_BITS] = tag_q;
      row_d[S_LO + 32'(way)*StampW +: StampW]     = acc_d;
      row_d[D_LO + 32'(way)]                      = (act_q == ActWrite);
      row_d[V_LO + 32'(way)]                      = 1'b1;
      if (sel.wb) begin
        wb_cnt_d = wb_cnt_q + StatW'(1);
      end
      if (act_q == ActWrite) begin
        wr_miss_d = wr_miss_q + StatW'(1);
      end else begin
        rd_miss_d = rd_miss_q + StatW'(1);
      end
    end
  end

  // Set memory: clearing writes, write-back of the updated row, row read.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      mem[clr_idx_q] <= '0;
    end else if (commit) begin
      mem[set_q] <= row_d;
    end
    if (in_acc) begin
      rdata_q <= mem[set_in];
    end
  end

  // Request payload held for the lookup cycle.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      set_q <= set_in;
      tag_q <= tag_in;
      act_q <= s_axis_tdata[0];
    end
  end

  // Control, configuration, statistics and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_idx_q  <= '0;
      policy_q   <= PolicyLru;
      n_ways_q   <= CNT_W'(N_RST);
      acc_q      <= '0;
      rd_hit_q   <= '0;
      rd_miss_q  <= '0;
      wr_hit_q   <= '0;
      wr_miss_q  <= '0;
      wb_cnt_q   <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgPolicy: policy_q <= cfg_data_i[0];
          CfgWays:   n_ways_q <= n_ways_d;
          default:   ;
        endcase
      end
      if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_idx_q <= clr_idx_q + SET_W'(1);
          if (clr_idx_q == SET_W'(SETS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (commit) begin
            state_q    <= ST_IDLE;
            acc_q      <= acc_d;
            rd_hit_q   <= rd_hit_d;
            rd_miss_q  <= rd_miss_d;
            wr_hit_q   <= wr_hit_d;
            wr_miss_q  <= wr_miss_d;
            wb_cnt_q   <= wb_cnt_d;
            out_vld_q  <= 1'b1;
            out_data_q <= {3'b000, wb_cnt_d, wr_miss_d, wr_hit_d, rd_miss_d, rd_hit_d,
                           WayOutW'(sel.way), sel.wb, sel.hit};
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/sactl_way_select.sv =====
// Way search of one cache set: hit detection and victim choice.
// Depends on sactl_pkg for the selection result type.
module sactl_way_select
  import sactl_pkg::*;
#(
  parameter int WAYS     = 8,
  parameter int TAG_BITS = 20,
  parameter int CNT_W    = 4
) (
  input  logic [WAYS-1:0]            valid_i,
  input  logic [WAYS-1:0]            dirty_i,
  input  logic [WAYS*TAG_BITS-1:0]   tags_i,
  input  logic [WAYS*StampW-1:0]     stamps_i,
  input  logic [TAG_BITS-1:0]        tag_i,
  input  logic [CNT_W-1:0]           n_ways_i,
  output sel_t                       sel_o
);

  logic               hit;
  logic [WayMaxW-1:0] hit_way;
  logic               free;
  logic [WayMaxW-1:0] free_way;
  logic [StampW-1:0]  best;
  logic [WayMaxW-1:0] lru_way;
  logic [WayMaxW-1:0] way;

  // First matching way, first invalid way and oldest stamp among searched ways.
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    best     = stamps_i[0 +: StampW];
    lru_way  = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (32'(j) < 32'(n_ways_i)) begin
        if (valid_i[j] && tags_i[j*TAG_BITS +: TAG_BITS] == tag_i) begin
          hit     = 1'b1;
          hit_way = WayMaxW'(j);
        end
        if (!valid_i[j]) begin
          free     = 1'b1;
          free_way = WayMaxW'(j);
        end
      end
    end
    for (int j = 1; j < WAYS; j++) begin
      if (32'(j) < 32'(n_ways_i) && stamps_i[j*StampW +: StampW] < best) begin
        best    = stamps_i[j*StampW +: StampW];
        lru_way = WayMaxW'(j);
      end
    end
    way = hit ? hit_way : (free ? free_way : lru_way);
    sel_o.hit = hit;
    sel_o.way = way;
    sel_o.wb  = !hit && valid_i[way[$clog2(WAYS > 1 ? WAYS : 2)-1:0]]
                && dirty_i[way[$clog2(WAYS > 1 ? WAYS : 2)-1:0]];
  end

endmodule

// ===== src/sactl_checker.sv =====
// Port-level checker of the set-associative cache tag lookup, with its bind.
// Depends on set_assoc_cache_tag_lookup_defines.svh for the assertion macros.
`include "set_assoc_cache_tag_lookup_defines.svh"

module sactl_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         cfg_we_i,
  input logic         cfg_idx_i,
  input logic [3:0]   cfg_data_i,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [31:0]  s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [167:0] m_axis_tdata
);

  // A stalled result holds its data.
  `SACTL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // A hit never evicts a line.
  `SACTL_ASSERT_NOW(a_hit_no_wb, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[1], "write-back reported on a hit")

  // A reported write-back is counted in the statistics.
  `SACTL_ASSERT_NOW(a_wb_counted, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[164:133] != 32'd0, "write-back not counted")

endmodule

bind set_assoc_cache_tag_lookup sactl_checker u_sactl_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench of the set-associative cache tag lookup.
// Depends on sactl_pkg and set_assoc_cache_tag_lookup; predicts each result from its own model.
module tb_top;
  import sactl_pkg::*;

  localparam int NWAYS = 8;
  localparam int NSETS = 256;
  localparam int LIMIT = 400000;

  // Result fields from the highest bit down; hit sits in bit 0.
  typedef struct packed {
    logic [31:0] wbacks;
    logic [31:0] wr_misses;
    logic [31:0] wr_hits;
    logic [31:0] rd_misses;
    logic [31:0] rd_hits;
    logic [2:0]  way;
    logic        wb;
    logic        hit;
  } lookup_res_t;

  // Cache model and queue of predicted lookup results.
  class lookup_scoreboard;
    bit          valid_q [NSETS*NWAYS];
    bit          dirty_q [NSETS*NWAYS];
    bit [19:0]   tag_q   [NSETS*NWAYS];
    bit [31:0]   stamp_q [NSETS*NWAYS];
    bit [31:0]   counter, rh, rm, wh, wm, wbc;
    bit          policy;
    bit [3:0]    ways_cfg;
    lookup_res_t pending_q[$];
    int          errors;

    function void clear();
      foreach (valid_q[i]) begin
        valid_q[i] = 0; dirty_q[i] = 0; tag_q[i] = '0; stamp_q[i] = '0;
      end
      counter = 0; rh = 0; rm = 0; wh = 0; wm = 0; wbc = 0;
      policy = PolicyLru; ways_cfg = 4'd8; errors = 0;
    endfunction

    // Notes an accepted request and predicts its result.
    function void note_request(bit act, bit [7:0] set_idx, bit [19:0] tg);
      int n, base, way, e;
      bit hit, wb, found;
      bit [31:0] best;
      lookup_res_t r;
      n = (ways_cfg == 0) ? 1 : ((ways_cfg > NWAYS) ? NWAYS : ways_cfg);
      base = set_idx * NWAYS;
      hit = 0; wb = 0; way = 0; found = 0;
      counter++;
      for (int j = 0; j < n; j++)
        if (!hit && valid_q[base+j] && tag_q[base+j] == tg) begin
          hit = 1; way = j;
        end
      if (hit) begin
        e = base + way;
        if (policy == PolicyLru) stamp_q[e] = counter;
        if (act == ActWrite) begin
          dirty_q[e] = 1; wh++;
        end else begin
          rh++;
        end
      end else begin
        for (int j = 0; j < n; j++)
          if (!found && !valid_q[base+j]) begin
            found = 1; way = j;
          end
        if (!found) begin
          best = stamp_q[base]; way = 0;
          for (int j = 1; j < n; j++)
            if (stamp_q[base+j] < best) begin
              best = stamp_q[base+j]; way = j;
            end
        end
        e = base + way;
        if (valid_q[e] && dirty_q[e]) begin
          wb = 1; wbc++;
        end
        tag_q[e] = tg; stamp_q[e] = counter;
        dirty_q[e] = (act == ActWrite); valid_q[e] = 1;
        if (act == ActWrite) wm++; else rm++;
      end
      r = '{hit: hit, wb: wb, way: way[2:0], rd_hits: rh, rd_misses: rm,
            wr_hits: wh, wr_misses: wm, wbacks: wbc};
      pending_q.push_back(r);
    endfunction

    // Compares an accepted result with the oldest prediction.
    function void check_result(logic [167:0] data);
      lookup_res_t got, exp;
      got = data[164:0];
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.hit !== exp.hit) report("hit", exp.hit, got.hit);
      if (got.wb !== exp.wb) report("wrote_back", exp.wb, got.wb);
      if (got.way !== exp.way) report("way_used", exp.way, got.way);
      if (got.rd_hits !== exp.rd_hits) report("read_hit_count", exp.rd_hits, got.rd_hits);
      if (got.rd_misses !== exp.rd_misses)
        report("read_miss_count", exp.rd_misses, got.rd_misses);
      if (got.wr_hits !== exp.wr_hits) report("write_hit_count", exp.wr_hits, got.wr_hits);
      if (got.wr_misses !== exp.wr_misses)
        report("write_miss_count", exp.wr_misses, got.wr_misses);
      if (got.wbacks !== exp.wbacks) report("writeback_count", exp.wbacks, got.wbacks);
      if (data[167:165] !== 3'b000) report("padding", 0, data[167:165]);
    endfunction

    function void report(string field, logic [31:0] exp, logic [31:0] act);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, field, exp, act);
      errors++;
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic         cfg_idx_i = CfgPolicy;
  logic [3:0]   cfg_data_i = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [167:0] m_axis_tdata;

  lookup_scoreboard sb;
  int  cycles = 0;
  int  idle_pct = 16;
  bit  rx_hold = 0;
  bit  [19:0] tag_pool[8];

  set_assoc_cache_tag_lookup u_dut (.*);

  initial forever #4 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver side: random stalls, check of each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic write_cfg(logic idx, logic [3:0] val);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx == CfgPolicy) sb.policy = val[0]; else sb.ways_cfg = val;
    @(posedge clk_i);
  endtask

  // Offers one request and holds it until accepted.
  task automatic send_request(bit act, bit [7:0] set_idx, bit [19:0] tg);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {3'b000, tg, set_idx, act};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(act, set_idx, tg);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Random phase: mostly a few sets and a small tag pool so lines hit and evict.
  task automatic random_phase(int count);
    bit [7:0] s;
    for (int i = 0; i < count; i++) begin
      s = ($urandom_range(9) < 7) ? 8'($urandom_range(3)) : 8'($urandom);
      if ($urandom_range(9) < 8) send_request(1'($urandom), s, tag_pool[$urandom_range(7)]);
      else send_request(1'($urandom), s, 20'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    foreach (tag_pool[i]) tag_pool[i] = 20'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = 20'hFFFFF;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: field extremes, both actions, hits, fills, dirty evictions.
    write_cfg(CfgWays, 4'd2);
    send_request(ActWrite, 8'd0, 20'h00000);
    send_request(ActRead, 8'd255, 20'hFFFFF);
    send_request(ActRead, 8'd0, 20'h00000);
    send_request(ActWrite, 8'd0, 20'h12345);
    send_request(ActRead, 8'd0, 20'hABCDE);
    send_request(ActWrite, 8'd0, 20'h00000);
    send_request(ActRead, 8'd0, 20'h55555);
    send_request(ActWrite, 8'd170, 20'hAAAAA);
    send_request(ActRead, 8'd85, 20'h55555);
    drain();
    // Ways count zero acts as one; values above the way count act as all ways.
    write_cfg(CfgWays, 4'd0);
    send_request(ActWrite, 8'd1, 20'h1);
    send_request(ActWrite, 8'd1, 20'h2);
    send_request(ActRead, 8'd0, 20'h12345);
    drain();
    write_cfg(CfgWays, 4'd15);
    write_cfg(CfgPolicy, 4'(PolicyFifo));
    for (int i = 0; i < 10; i++) send_request(ActWrite, 8'd2, 20'(i));
    send_request(ActRead, 8'd2, 20'h3);
    drain();

    // Random phases over several settings.
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(CfgPolicy, 4'(ph[0]));
      write_cfg(CfgWays, (ph == 0) ? 4'd1 : (ph == 7) ? 4'd8 : 4'($urandom_range(15)));
      idle_pct = (ph == 3) ? 0 : 16;
      if (ph == 5) begin
        // Long receiver hold-off while requests keep coming.
        fork
          begin
            rx_hold = 1;
            repeat (300) @(posedge clk_i);
            rx_hold = 0;
          end
        join_none
      end
      random_phase(210);
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== set_assoc_cache_tag_lookup.f =====
+incdir+src
src/sactl_pkg.sv
src/sactl_way_select.sv
src/set_assoc_cache_tag_lookup.sv
src/sactl_checker.sv
tb/tb_top.sv
